### rtl/core/four_level_page_table_walker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page table walker
// Clocked property wrappers that report through $error.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Property checked at every clock edge outside reset
`define PTW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, codes and helpers shared by the page table walker modules.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int PHYS_ADDR_BITS_DEF = 52;
  localparam int VADDR_W            = 48;
  localparam int ENTRY_W            = 64;
  localparam int ADDR_W             = 52;
  localparam int ROOT_W             = 40;
  localparam int FAULT_W            = 3;
  localparam int FRAME_SHIFT        = 12;
  localparam int IDX_W              = 9;

  // Input commands
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Walk levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  // Fault codes
  localparam logic [FAULT_W-1:0] FLT_OK          = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_PML4_ABSENT = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_PDPT_ABSENT = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_1G_PAGE     = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_PD_ABSENT   = 3'd4;
  localparam logic [FAULT_W-1:0] FLT_2M_PAGE     = 3'd5;
  localparam logic [FAULT_W-1:0] FLT_PT_ABSENT   = 3'd6;

  // Entry bit positions
  localparam int ENTRY_PRESENT_BIT = 0;
  localparam int ENTRY_PS_BIT      = 7;

  typedef struct packed {
    logic               cmd;
    logic [VADDR_W-1:0] lookup_addr;
    logic [ENTRY_W-1:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  read_addr;
    logic [ADDR_W-1:0]  page_base;
    logic [ADDR_W-1:0]  leaf_entry_addr;
    logic [FAULT_W-1:0] fault;
  } out_item_t;

  // Walk control state
  typedef struct packed {
    logic       busy;
    logic [1:0] level;
  } walk_ctrl_t;

  // 9-bit table index of a virtual address at a given level
  function automatic logic [IDX_W-1:0] level_index(logic [VADDR_W-1:0] va,
                                                   logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Fault code for a non-present entry at a given level
  function automatic logic [FAULT_W-1:0] absent_code(logic [1:0] lvl);
    logic [FAULT_W-1:0] code;
    case (lvl)
      LVL_PML4: code = FLT_PML4_ABSENT;
      LVL_PDPT: code = FLT_PDPT_ABSENT;
      LVL_PD:   code = FLT_PD_ABSENT;
      default:  code = FLT_PT_ABSENT;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/ptw_step.sv
// ----------------------------------------------------------------------------
// ptw_step
// Next-state and result logic for one accepted item of the walker.
// ----------------------------------------------------------------------------
module ptw_step #(
  parameter int PA_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  ptw_pkg::in_item_t                 item,
  input  ptw_pkg::walk_ctrl_t               ctrl,
  input  logic [ptw_pkg::VADDR_W-1:0]       saved_vaddr,
  input  logic [PA_BITS-1:0]                pending_addr,
  input  logic [ptw_pkg::ROOT_W-1:0]        root_frame,
  output ptw_pkg::walk_ctrl_t               ctrl_next,
  output logic [ptw_pkg::VADDR_W-1:0]       saved_vaddr_next,
  output logic [PA_BITS-1:0]                pending_addr_next,
  output logic                              emit,
  output ptw_pkg::out_item_t                result
);
  import ptw_pkg::*;

  localparam int FRAME_W = PA_BITS - FRAME_SHIFT;

  logic             present;
  logic             large_page;
  logic [1:0]       level_up;
  logic [PA_BITS-1:0] root_addr;
  logic [PA_BITS-1:0] next_addr;

  // Entry checks and candidate read addresses (base low bits are zero: concat)
  assign present    = item.entry_data[ENTRY_PRESENT_BIT];
  assign large_page = item.entry_data[ENTRY_PS_BIT] &&
                      (ctrl.level == LVL_PDPT || ctrl.level == LVL_PD);
  assign level_up   = ctrl.level + 2'd1;
  assign root_addr  = {root_frame[FRAME_W-1:0],
                       level_index(item.lookup_addr, LVL_PML4), 3'b000};
  assign next_addr  = {item.entry_data[PA_BITS-1:FRAME_SHIFT],
                       level_index(saved_vaddr, level_up), 3'b000};

  // Walk sequencing
  always_comb begin
    ctrl_next         = ctrl;
    saved_vaddr_next  = saved_vaddr;
    pending_addr_next = pending_addr;
    emit              = 1'b0;
    result            = '0;
    if (item.cmd == CMD_TRANSLATE) begin
      if (!ctrl.busy) begin
        saved_vaddr_next  = item.lookup_addr;
        pending_addr_next = root_addr;
        ctrl_next.busy    = 1'b1;
        ctrl_next.level   = LVL_PML4;
        emit              = 1'b1;
        result.kind       = KIND_READ;
        result.read_addr  = ADDR_W'(root_addr);
      end
    end else if (ctrl.busy) begin
      emit = 1'b1;
      if (!present || large_page || ctrl.level == LVL_PT) begin
        // walk ends here, fault or leaf
        ctrl_next.busy         = 1'b0;
        ctrl_next.level        = LVL_PML4;
        result.kind            = KIND_DONE;
        result.leaf_entry_addr = ADDR_W'(pending_addr);
        if (!present) begin
          result.fault = absent_code(ctrl.level);
        end else if (large_page) begin
          result.fault = (ctrl.level == LVL_PDPT) ? FLT_1G_PAGE : FLT_2M_PAGE;
        end else begin
          result.fault     = FLT_OK;
          result.page_base = ADDR_W'({item.entry_data[PA_BITS-1:FRAME_SHIFT],
                                      {FRAME_SHIFT{1'b0}}});
        end
      end else begin
        // descend one level
        ctrl_next.level   = level_up;
        pending_addr_next = next_addr;
        result.kind       = KIND_READ;
        result.read_addr  = ADDR_W'(next_addr);
      end
    end
  end

endmodule

### rtl/core/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level x86-64 page table walk sequencer with a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one channel carries both translate requests (cmd 0, lookup_addr)
//           and memory read responses (cmd 1, entry_data).
//   out_* : read requests (kind 0, read_addr) and walk completions (kind 1,
//           page_base, leaf_entry_addr, fault).
//   cfg_* : writes the root table frame; always ready, write only when idle.
// A translate issues the PML4 read; each response either issues the next
// level's read or ends the walk. Requests while a walk is open and responses
// while idle are dropped without a result.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one item per cycle while the output is not stalled; the state update
// and result come from one level of entry checks and an address concat in front of the output register.
// Receiver stall: in_ready drops only while a result sits in the output
// register and out_ready is low; the result holds until transferred.
// Reset: walk idle, output empty, root frame zero.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ptw_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ptw_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptw_pkg::ROOT_W-1:0]  cfg_data
);
  import ptw_pkg::*;

  walk_ctrl_t                ctrl;
  walk_ctrl_t                ctrl_next;
  logic [VADDR_W-1:0]        saved_vaddr;
  logic [VADDR_W-1:0]        saved_vaddr_next;
  logic [PHYS_ADDR_BITS-1:0] pending_addr;
  logic [PHYS_ADDR_BITS-1:0] pending_addr_next;
  logic [ROOT_W-1:0]         root_frame;
  logic                      emit;
  out_item_t                 result;
  logic                      in_fire;

  // Handshakes
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  ptw_step #(
    .PA_BITS (PHYS_ADDR_BITS)
  ) u_step (
    .item              (in_data),
    .ctrl              (ctrl),
    .saved_vaddr       (saved_vaddr),
    .pending_addr      (pending_addr),
    .root_frame        (root_frame),
    .ctrl_next         (ctrl_next),
    .saved_vaddr_next  (saved_vaddr_next),
    .pending_addr_next (pending_addr_next),
    .emit              (emit),
    .result            (result)
  );

  // Root table frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_frame <= cfg_data;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (in_fire) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      saved_vaddr  <= saved_vaddr_next;
      pending_addr <= pending_addr_next;
    end
  end

  // Output register; slot is free whenever in_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data <= result;
    end
  end

endmodule

### rtl/core/ptw_checker.sv
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks for the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_assert.svh"

module ptw_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ptw_pkg::out_item_t out_data
);
  import ptw_pkg::*;

  // Output register empties on reset
  `PTW_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "output valid after reset")

  // A stalled result holds its payload
  `PTW_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // A stalled result blocks new input transfers
  `PTW_ASSERT(a_stall_block, clk, rst, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")

  // With the output slot free the walker takes input
  `PTW_ASSERT(a_free_ready, clk, rst, !out_valid |-> in_ready, "input not ready with empty output")

  // A result only follows an input transfer
  `PTW_ASSERT(a_out_from_input, clk, rst, !out_valid && !(in_valid && in_ready) |=> !out_valid, "result without an input transfer")

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
